/* hdl/pacl_pkg.sv */
// shared types, codes and the prefix mask helper for the prefix match table
package pacl_pkg;

   localparam int DEF_TABLE_DEPTH = 32;
   localparam int KEY_W = 128;
   localparam int PLEN_W = 8;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

   localparam logic [PLEN_W-1:0] V4_MAX_LEN = 8'd32;
   localparam logic [PLEN_W-1:0] V6_MAX_LEN = 8'd128;
   // an ipv4 prefix is placed at the bottom of the 128-bit key
   localparam logic [PLEN_W-1:0] V4_LEN_OFFSET = 8'd96;

   typedef struct packed {
      logic [1:0]  action;
      logic        family;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [7:0]  prefix_len;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  addr;
      logic [PLEN_W-1:0] prefix;
      logic              is_v6;
   } ent_type;

   // leading-ones mask of the given length over the whole key
   function automatic logic [KEY_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
      logic [KEY_W-1:0] m;
      if (len == '0) begin
         m = '0;
      end else begin
         m = {KEY_W{1'b1}} << (PLEN_W'(KEY_W) - len);
      end
      return m;
   endfunction

endpackage

/* hdl/prefix_acl_match_table.sv */
// prefix match table: ipv4/ipv6 prefix store with a sequential lookup scan
// clear, insert and the unused action: result registered in the next cycle.
// lookup: one stored entry per cycle through one masked compare unit and a registered
//   memory read; stops at the first hit, an empty table answers without a scan.
// one request at a time; a new request is taken once the result slot is free.
// reset clears count and state, not the store; entries are never read past the count.
module prefix_acl_match_table #(
   parameter int TABLE_DEPTH = pacl_pkg::DEF_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pacl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pacl_pkg::rsp_type rsp_data
);
   import pacl_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             cmp_last_ff, cmp_last_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             fam_ff, fam_in;
   logic             res_hit_ff, res_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   ent_type          mem [TABLE_DEPTH];
   ent_type          rd_ent_ff;
   ent_type          ent_wr;
   logic             mem_we;

   logic             req_fire;
   logic             rsp_free;
   logic [KEY_W-1:0] req_key;
   logic             plen_bad;
   logic             tbl_full;
   logic             scan_issue;
   logic             scan_done;
   logic             hit;

   // shared masked compare unit
   logic             unit_fam;
   logic [PLEN_W-1:0] unit_plen;
   logic [KEY_W-1:0] unit_key;
   logic [PLEN_W-1:0] mask_len;
   logic [KEY_W-1:0] masked_key;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_key  = req_data.family ? {req_data.addr_upper, req_data.addr_lower}
                                     : {96'b0, req_data.addr_lower[31:0]};
   assign plen_bad = req_data.prefix_len > (req_data.family ? V6_MAX_LEN : V4_MAX_LEN);
   assign tbl_full = cnt_ff >= CNT_W'(TABLE_DEPTH);

   always_comb begin
      if (state_ff == S_IDLE) begin
         unit_fam  = req_data.family;
         unit_plen = req_data.prefix_len;
         unit_key  = req_key;
      end else begin
         unit_fam  = fam_ff;
         unit_plen = rd_ent_ff.prefix;
         unit_key  = key_ff;
      end
   end

   assign mask_len   = unit_fam ? unit_plen : unit_plen + V4_LEN_OFFSET;
   assign masked_key = unit_key & prefix_mask(mask_len);

   assign hit = cmp_vld_ff && (rd_ent_ff.is_v6 == fam_ff) && (masked_key == rd_ent_ff.addr);

   assign scan_issue = (state_ff == S_SCAN) && (rd_idx_ff < cnt_ff);
   assign scan_done  = (state_ff == S_SCAN) && cmp_vld_ff && (hit || cmp_last_ff);

   assign ent_wr.addr   = masked_key;
   assign ent_wr.prefix = req_data.prefix_len;
   assign ent_wr.is_v6  = req_data.family;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_last_in  = 1'b0;
      key_in       = key_ff;
      fam_in       = fam_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_in.matched = 1'b0;
               rsp_in.status  = STATUS_OK;
               case (req_data.action)
                  ACT_CLEAR: begin
                     cnt_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (plen_bad) begin
                        rsp_in.status = STATUS_BAD_LEN;
                     end else if (tbl_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  ACT_LOOKUP: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        key_in    = req_key;
                        fam_in    = req_data.family;
                        rd_idx_in = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            cmp_vld_in  = scan_issue && !scan_done;
            cmp_last_in = rd_idx_ff == (cnt_ff - CNT_W'(1));
            if (scan_done) begin
               if (rsp_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.matched = hit;
                  rsp_in.status  = STATUS_OK;
                  state_in       = S_IDLE;
               end else begin
                  res_hit_in = hit;
                  state_in   = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.matched = res_hit_ff;
               rsp_in.status  = STATUS_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         cmp_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_last_ff  <= cmp_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff     <= key_in;
      fam_ff     <= fam_in;
      res_hit_ff <= res_hit_in;
      rsp_ff     <= rsp_in;
   end

   // entry store: appended at the count, read one entry per cycle during a scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= ent_wr;
      end
      if (scan_issue) begin
         rd_ent_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while a lookup is in progress");

   a_cmp_only_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == S_SCAN))
      else $error("compare stage live outside a scan");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.action == ACT_INSERT && !plen_bad && !tbl_full)
      |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not advance the entry count");

   a_err_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |-> !rsp_ff.matched)
      else $error("error status with match flag set");
`endif

endmodule

/* tb/prefix_acl_match_table_tb.sv */
// testbench for the prefix match table: directed and random requests against a local table model
`timescale 1ns / 1ps

module prefix_acl_match_table_tb;
   import pacl_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic FAM_V4 = 1'b0;
   localparam logic FAM_V6 = 1'b1;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   prefix_acl_match_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // local copy of the prefix table
   logic [127:0] tbl_key [DEPTH];
   logic [7:0]   tbl_len [DEPTH];
   logic         tbl_v6 [DEPTH];
   logic         tbl_used [DEPTH];
   int unsigned  tbl_count = 0;

   rsp_type     verdict_q[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("prefix_acl_match_table test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // leading-ones mask of a prefix over the 128-bit key; ipv4 lives in bits 31..0
   function automatic logic [127:0] addr_mask(input logic v6, input logic [7:0] plen);
      logic [127:0] ones;
      ones = '1;
      if (plen == 8'd0) return '0;
      if (v6) return ones << (128 - int'(plen));
      return (ones << (32 - int'(plen))) & 128'hFFFF_FFFF;
   endfunction

   function automatic logic [127:0] addr_key(input logic v6, input logic [63:0] au,
                                             input logic [63:0] al);
      if (v6) return {au, al};
      return {96'd0, al[31:0]};
   endfunction

   function automatic req_type mk_req(input logic [1:0] act, input logic fam,
                                      input logic [63:0] au, input logic [63:0] al,
                                      input logic [7:0] plen);
      req_type r;
      r.action = act;
      r.family = fam;
      r.addr_upper = au;
      r.addr_lower = al;
      r.prefix_len = plen;
      return r;
   endfunction

   // applies one request to the local table and returns the expected result
   function automatic rsp_type acl_table_step(input req_type r);
      rsp_type      res;
      logic [127:0] k;
      logic [7:0]   max_len;
      res = '0;
      k = addr_key(r.family, r.addr_upper, r.addr_lower);
      max_len = (r.family == FAM_V6) ? V6_MAX_LEN : V4_MAX_LEN;
      case (r.action)
         ACT_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
            tbl_count = 0;
         end
         ACT_INSERT: begin
            if (r.prefix_len > max_len) begin
               res.status = STATUS_BAD_LEN;
            end else if (tbl_count >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               tbl_key[tbl_count] = k & addr_mask(r.family, r.prefix_len);
               tbl_len[tbl_count] = r.prefix_len;
               tbl_v6[tbl_count] = r.family;
               tbl_used[tbl_count] = 1'b1;
               tbl_count++;
               res.status = STATUS_OK;
            end
         end
         ACT_LOOKUP: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (tbl_used[i] && tbl_v6[i] == r.family &&
                   (k & addr_mask(tbl_v6[i], tbl_len[i])) == tbl_key[i])
                  res.matched = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic req_type good_insert();
      logic       fam;
      logic [7:0] plen;
      fam = 1'($urandom);
      if ($urandom_range(0, 99) < 20) begin
         case ($urandom_range(0, 3))
            0: plen = 8'd0;
            1: plen = 8'd1;
            2: plen = fam ? 8'd64 : 8'd31;
            default: plen = fam ? V6_MAX_LEN : V4_MAX_LEN;
         endcase
      end else begin
         plen = 8'($urandom_range(0, fam ? 128 : 32));
      end
      return mk_req(ACT_INSERT, fam, rand64(), rand64(), plen);
   endfunction

   function automatic req_type bad_len_insert();
      logic fam;
      fam = 1'($urandom);
      return mk_req(ACT_INSERT, fam, rand64(), rand64(),
                    8'($urandom_range(fam ? 129 : 33, 255)));
   endfunction

   // addresses inside a stored prefix with random host bits, some one bit outside, or random
   function automatic req_type lookup_probe();
      logic [127:0] k, m;
      logic         fam;
      int unsigned  slot, bit_idx;
      if (tbl_count != 0 && $urandom_range(0, 99) < 65) begin
         slot = $urandom_range(0, tbl_count - 1);
         fam = tbl_v6[slot];
         m = addr_mask(fam, tbl_len[slot]);
         k = tbl_key[slot] ^ ({rand64(), rand64()} & ~m);
         if (tbl_len[slot] != 8'd0 && $urandom_range(0, 99) < 30) begin
            bit_idx = (fam ? 127 : 31) - $urandom_range(0, tbl_len[slot] - 1);
            k[bit_idx] = ~k[bit_idx];
         end
      end else begin
         fam = 1'($urandom);
         k = {rand64(), rand64()};
      end
      if (fam == FAM_V6)
         return mk_req(ACT_LOOKUP, fam, k[127:64], k[63:0], 8'($urandom));
      return mk_req(ACT_LOOKUP, fam, rand64(), {$urandom, k[31:0]}, 8'($urandom));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      verdict_q.push_back(acl_table_step(r));
      @(negedge clock);
   endtask

   task automatic test_prefix_basics();
      send_request(mk_req(ACT_CLEAR, FAM_V4, '0, '0, '0));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, '0, '0, '0));
      // host bits and the unused upper bits must not matter
      send_request(mk_req(ACT_INSERT, FAM_V4, '1, 64'hFFFF_FFFF_0A12_3456, 8'd8));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, '1, 64'h0000_0000_0AFF_FFFF, '0));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, '0, 64'h0B00_0000, '0));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, '0, 64'h0A00_0000, '0));
      send_request(mk_req(ACT_INSERT, FAM_V6, '1, '1, V6_MAX_LEN));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, '1, '1, '0));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0));
      send_request(mk_req(ACT_INSERT, FAM_V4, '0, 64'hFFFF_FFFF, V4_MAX_LEN));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, '0, 64'hFFFF_FFFF, '0));
      // zero prefix covers the whole family
      send_request(mk_req(ACT_INSERT, FAM_V6, rand64(), rand64(), 8'd0));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, '0, '0, '0));
      send_request(mk_req(ACT_INSERT, FAM_V4, rand64(), rand64(), 8'd0));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, rand64(), rand64(), '1));
   endtask

   task automatic test_prefix_length_limits();
      send_request(mk_req(ACT_CLEAR, FAM_V6, '1, '1, '1));
      send_request(mk_req(ACT_INSERT, FAM_V4, '0, 64'h0A00_0000, 8'd33));
      send_request(mk_req(ACT_INSERT, FAM_V4, '0, 64'h0A00_0000, 8'd255));
      send_request(mk_req(ACT_INSERT, FAM_V6, '1, '1, 8'd129));
      send_request(mk_req(ACT_INSERT, FAM_V6, '1, '1, 8'd255));
      send_request(mk_req(ACT_LOOKUP, FAM_V4, '0, 64'h0A00_0000, '0));
      send_request(mk_req(ACT_INSERT, FAM_V6, 64'h2001_0DB8_0000_0001, '1, 8'd64));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, 64'h2001_0DB8_0000_0001, '0, '0));
   endtask

   task automatic test_unused_action();
      send_request(mk_req(ACT_SPARE, FAM_V6, '1, '1, '1));
      send_request(mk_req(ACT_LOOKUP, FAM_V6, 64'h2001_0DB8_0000_0001, '1, '0));
   endtask

   task automatic test_full_table();
      send_request(mk_req(ACT_CLEAR, FAM_V4, '0, '0, '0));
      repeat (DEPTH) send_request(good_insert());
      send_request(good_insert());
      // the length check wins over the full check
      send_request(bad_len_insert());
      send_request(lookup_probe());
      send_request(lookup_probe());
      send_request(mk_req(ACT_CLEAR, FAM_V4, '0, '0, '0));
      send_request(good_insert());
   endtask

   // episodes of clear, inserts and lookups, with some noise
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned sent, ins_weight, ep_len, roll;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 2))
            0: ins_weight = 15;
            1: ins_weight = 40;
            default: ins_weight = 75;
         endcase
         if ($urandom_range(0, 99) < 70) begin
            send_request(mk_req(ACT_CLEAR, 1'($urandom), rand64(), rand64(), 8'($urandom)));
            sent++;
         end
         ep_len = $urandom_range(4, 60);
         for (int j = 0; j < ep_len && sent < n_items; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_weight) begin
               send_request(good_insert());
               sent++;
            end else if (roll < ins_weight + 4) begin
               send_request(bad_len_insert());
               sent++;
            end else if (roll < 94) begin
               send_request(lookup_probe());
               sent++;
            end else if (roll < 97) begin
               send_request(mk_req(ACT_SPARE, 1'($urandom), rand64(), rand64(), 8'($urandom)));
               sent++;
            end else begin
               send_request(mk_req(2'($urandom), 1'($urandom), rand64(), rand64(),
                                   8'($urandom)));
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: matched=%0b status=%0d",
                        rsp_data.matched, rsp_data.status);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.matched !== want.matched || rsp_data.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result mismatch: expected matched=%0b status=%0d, ",
                            "got matched=%0b status=%0d"},
                           want.matched, want.status, rsp_data.matched, rsp_data.status);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 35;
      rsp_stall_pct = 73;
      test_prefix_basics();
      test_prefix_length_limits();
      test_unused_action();
      test_full_table();
      test_random_traffic(460);

      req_idle_pct = 73;
      rsp_stall_pct = 35;
      test_random_traffic(460);

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(466);

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("prefix_acl_match_table test passed");
      end else begin
         $display("prefix_acl_match_table test failed");
      end
      $finish;
   end

endmodule
